[rtl/isaac_pkg.sv]
package isaac_pkg;

  localparam int POOL_WORDS = 256;
  localparam int IDX_W = 8;

  localparam logic [31:0] GOLDEN = 32'h9e3779b9;

  typedef enum logic [1:0] {
    OP_LOAD      = 2'd0,
    OP_INIT_SEED = 2'd1,
    OP_INIT_ZERO = 2'd2,
    OP_NEXT      = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE,
    ST_FRD,
    ST_FMIX,
    ST_FWR,
    ST_N0,
    ST_N1,
    ST_N2,
    ST_N3,
    ST_N4,
    ST_OUT,
    ST_CLR
  } state_t;

  typedef logic [31:0] mix_t [8];

  // one line of the scramble network; eight lines in order make one scramble
  function automatic mix_t mix_line(input mix_t vi, input logic [2:0] s);
    mix_t v;
    logic [31:0] t;
    logic [2:0] i1, i2, i3;
    v = vi;
    i1 = s + 3'd1;
    i2 = s + 3'd2;
    i3 = s + 3'd3;
    unique case (s)
      3'd0: t = v[i1] << 11;
      3'd1: t = v[i1] >> 2;
      3'd2: t = v[i1] << 8;
      3'd3: t = v[i1] >> 16;
      3'd4: t = v[i1] << 10;
      3'd5: t = v[i1] >> 4;
      3'd6: t = v[i1] << 8;
      default: t = v[i1] >> 9;
    endcase
    v[s] = v[s] ^ t;
    v[i3] = v[i3] + v[s];
    v[i1] = v[i1] + v[i2];
    return v;
  endfunction

endpackage

[rtl/isaac_random_generator.sv]
// ISAAC-32 generator. Send load words (op 0) to fill the seed store, then init
// (op 1 with seed, op 2 without), then next words (op 3) for one result each.
// A next word makes four reads, two of them dependent, and one write on the
// single-port pool memory, and the block takes no new word until the write is
// done; while the previous result still waits on out_tready the step holds
// before its write. Init runs a premix, then two passes with seed (one
// without) of 32 blocks, each block read, mixed and written back word by word.
// After reset a clearing pass zeroes all 256 words of the seed store before the
// first word is taken. A load word writes the seed store and leaves the block
// idle, ready for the next word.
module isaac_random_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // operation[1:0], seed_index[9:2], seed_word[41:10]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata  // random_word[31:0]
);
  localparam int AW = isaac_pkg::IDX_W;

  logic [31:0] pool_mem [isaac_pkg::POOL_WORDS];
  logic [31:0] seed_mem [isaac_pkg::POOL_WORDS];
  logic [31:0] pool_q, seed_q;
  logic [AW-1:0] p_addr, s_addr;
  logic p_we, s_we;
  logic [31:0] p_wd, s_wd;

  always_ff @(posedge clk) begin
    if (p_we) pool_mem[p_addr] <= p_wd;
    pool_q <= pool_mem[p_addr];
  end
  always_ff @(posedge clk) begin
    if (s_we) seed_mem[s_addr] <= s_wd;
    seed_q <= seed_mem[s_addr];
  end

  isaac_pkg::state_t st_r, st_nxt;
  isaac_pkg::mix_t v_r, v_nxt;
  logic [31:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, x_r, x_nxt, y_r, y_nxt;
  logic [AW-1:0] idx_r, idx_nxt, cnt_r, cnt_nxt;
  logic [4:0] k_r, k_nxt;
  logic pass_r, pass_nxt, useseed_r, useseed_nxt;
  logic [31:0] out_r, out_nxt;
  logic ov_r, ov_nxt;
  logic [1:0] op;
  logic [AW-1:0] sidx;
  logic [31:0] sword, amix, src;

  assign op    = in_tdata[1:0];
  assign sidx  = in_tdata[2 +: AW];
  assign sword = in_tdata[41:10];
  assign in_tready  = (st_r == isaac_pkg::ST_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = out_r;

  always_comb begin
    unique case (idx_r[1:0])
      2'd0: amix = a_r ^ (a_r << 13);
      2'd1: amix = a_r ^ (a_r >> 6);
      2'd2: amix = a_r ^ (a_r << 2);
      default: amix = a_r ^ (a_r >> 16);
    endcase
  end
  assign src = pass_r ? pool_q : seed_q;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      isaac_pkg::ST_CLR:  if (&cnt_r) st_nxt = isaac_pkg::ST_IDLE;
      isaac_pkg::ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          unique case (op)
            isaac_pkg::OP_LOAD: st_nxt = isaac_pkg::ST_IDLE;
            isaac_pkg::OP_NEXT: st_nxt = isaac_pkg::ST_N0;
            default:            st_nxt = isaac_pkg::ST_PRE;
          endcase
        end
      end
      isaac_pkg::ST_PRE:  if (k_r == 5'd31) st_nxt = isaac_pkg::ST_FRD;
      isaac_pkg::ST_FRD:  if (k_r == 5'd8) st_nxt = isaac_pkg::ST_FMIX;
      isaac_pkg::ST_FMIX: if (k_r == 5'd7) st_nxt = isaac_pkg::ST_FWR;
      isaac_pkg::ST_FWR: begin
        if (k_r == 5'd7) begin
          if (&cnt_r[AW-1:3])
            st_nxt = (useseed_r && !pass_r) ? isaac_pkg::ST_FRD : isaac_pkg::ST_IDLE;
          else
            st_nxt = isaac_pkg::ST_FRD;
        end
      end
      isaac_pkg::ST_N0:  st_nxt = isaac_pkg::ST_N1;
      isaac_pkg::ST_N1:  st_nxt = isaac_pkg::ST_N2;
      isaac_pkg::ST_N2:  st_nxt = isaac_pkg::ST_N3;
      isaac_pkg::ST_N3:  st_nxt = isaac_pkg::ST_N4;
      isaac_pkg::ST_N4:  if (!ov_r || out_tready) st_nxt = isaac_pkg::ST_OUT;
      isaac_pkg::ST_OUT: st_nxt = isaac_pkg::ST_IDLE;
      default:           st_nxt = isaac_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    v_nxt = v_r; a_nxt = a_r; b_nxt = b_r; c_nxt = c_r; x_nxt = x_r; y_nxt = y_r;
    idx_nxt = idx_r; cnt_nxt = cnt_r; k_nxt = k_r; pass_nxt = pass_r;
    useseed_nxt = useseed_r; out_nxt = out_r; ov_nxt = ov_r;
    p_addr = idx_r; p_we = 1'b0; p_wd = y_r;
    s_addr = cnt_r; s_we = 1'b0; s_wd = '0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (st_r)
      isaac_pkg::ST_CLR: begin
        s_we = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
      end
      isaac_pkg::ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          unique case (op)
            isaac_pkg::OP_LOAD: begin
              s_addr = sidx; s_we = 1'b1; s_wd = sword;
            end
            isaac_pkg::OP_NEXT: ;
            default: begin
              for (int i = 0; i < 8; i++) v_nxt[i] = isaac_pkg::GOLDEN;
              a_nxt = '0; b_nxt = '0; c_nxt = '0; idx_nxt = '0;
              k_nxt = '0; cnt_nxt = '0; pass_nxt = 1'b0;
              useseed_nxt = (op == isaac_pkg::OP_INIT_SEED);
            end
          endcase
        end
      end
      isaac_pkg::ST_PRE: begin
        v_nxt = isaac_pkg::mix_line(v_r, k_r[2:0]);
        k_nxt = k_r + 5'd1;
      end
      isaac_pkg::ST_FRD: begin
        // issue read at cnt (k<8), capture previous (k>0)
        p_addr = cnt_r; s_addr = cnt_r;
        if (k_r != 5'd0 && useseed_r) v_nxt[k_r[2:0] - 3'd1] = v_r[k_r[2:0] - 3'd1] + src;
        if (k_r == 5'd8) begin
          k_nxt = '0; cnt_nxt = {cnt_r[AW-1:3], 3'd0};
        end else begin
          k_nxt = k_r + 5'd1;
          if (k_r != 5'd7) cnt_nxt = cnt_r + 1'b1;
        end
      end
      isaac_pkg::ST_FMIX: begin
        v_nxt = isaac_pkg::mix_line(v_r, k_r[2:0]);
        k_nxt = (k_r == 5'd7) ? 5'd0 : k_r + 5'd1;
      end
      isaac_pkg::ST_FWR: begin
        p_addr = cnt_r; p_we = 1'b1; p_wd = v_r[k_r[2:0]];
        cnt_nxt = cnt_r + 1'b1;
        if (k_r == 5'd7) begin
          k_nxt = '0;
          if (&cnt_r[AW-1:3]) pass_nxt = 1'b1;
        end else k_nxt = k_r + 5'd1;
      end
      isaac_pkg::ST_N0: begin
        p_addr = idx_r;
        if (idx_r == '0) begin
          c_nxt = c_r + 32'd1; b_nxt = b_r + c_r + 32'd1;
        end
      end
      isaac_pkg::ST_N1: begin
        x_nxt = pool_q;
        p_addr = idx_r + AW'(isaac_pkg::POOL_WORDS / 2);
      end
      isaac_pkg::ST_N2: begin
        a_nxt = amix + pool_q;
        p_addr = x_r[2 +: AW];
      end
      isaac_pkg::ST_N3: begin
        y_nxt = pool_q + a_r + b_r;
        p_addr = idx_r;
      end
      isaac_pkg::ST_N4: begin
        p_addr = y_r[10 +: AW];
      end
      isaac_pkg::ST_OUT: begin
        // y>>10 was read before y lands at idx; forward y when they match
        p_addr = idx_r; p_we = 1'b1; p_wd = y_r;
        b_nxt = ((y_r[10 +: AW] == idx_r) ? y_r : pool_q) + x_r;
        out_nxt = ((y_r[10 +: AW] == idx_r) ? y_r : pool_q) + x_r;
        ov_nxt = 1'b1;
        idx_nxt = idx_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= isaac_pkg::ST_CLR;
      cnt_r <= '0; ov_r <= 1'b0; idx_r <= '0;
      a_r <= '0; b_r <= '0; c_r <= '0;
      k_r <= '0; pass_r <= 1'b0; useseed_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; ov_r <= ov_nxt; idx_r <= idx_nxt;
      a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt;
      k_r <= k_nxt; pass_r <= pass_nxt; useseed_r <= useseed_nxt;
    end
  end
  always_ff @(posedge clk) begin
    v_r <= v_nxt; x_r <= x_nxt; y_r <= y_nxt; out_r <= out_nxt;
  end
endmodule
